FILE: hdl/nvmeqp_pkg.sv
// Shared types and constants of the NVMe I/O queue pair host engine.
package nvmeqp_pkg;

   localparam int SQ_DEPTH_MAX = 64;
   localparam int CQ_DEPTH_MAX = 256;

   // Input item function codes
   localparam logic FUNC_SUBMIT   = 1'b0;
   localparam logic FUNC_COMPLETE = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_ISSUED  = 2'd0;
   localparam logic [1:0] KIND_FULL    = 2'd1;
   localparam logic [1:0] KIND_CPL_OK  = 2'd2;
   localparam logic [1:0] KIND_CPL_ERR = 2'd3;

   // Command opcodes
   localparam logic [7:0] OPC_WRITE = 8'h01;
   localparam logic [7:0] OPC_READ  = 8'h02;

   // Configuration register indexes
   localparam logic [2:0] REG_BLOCK_SIZE   = 3'd0;
   localparam logic [2:0] REG_MAX_TRANSFER = 3'd1;
   localparam logic [2:0] REG_NAMESPACE    = 3'd2;
   localparam logic [2:0] REG_SQ_ENTRIES   = 3'd3;
   localparam logic [2:0] REG_CQ_ENTRIES   = 3'd4;

   typedef struct packed {
      logic        func;
      logic [47:0] buf_addr;
      logic [63:0] start_block;
      logic [16:0] block_count;
      logic        is_write;
      logic [15:0] cqe_status;
      logic [5:0]  cqe_sq_head;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  slot_index;
      logic [31:0] cmd_dword0;
      logic [47:0] data_pointer;
      logic [31:0] cmd_namespace;
      logic [63:0] cmd_block;
      logic [31:0] cmd_dword12;
      logic [16:0] granted_count;
      logic [7:0]  doorbell_value;
      logic [7:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  block_size_log2;
      logic [3:0]  max_transfer_log2;
      logic [31:0] namespace_id;
      logic [6:0]  sq_entries;
      logic [8:0]  cq_entries;
   } cfg_type;

   // Classified item handed from the front to the back
   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  slot;
      logic        is_write;
      logic [47:0] buf_addr;
      logic [63:0] start_block;
      logic [16:0] block_count;
      logic [7:0]  doorbell;
      logic [7:0]  error_code;
   } work_type;

endpackage

FILE: hdl/nvmeqp_fifo.sv
// Small synchronous queue used between the engine stages and at the result side.
module nvmeqp_fifo #(
   parameter int DEPTH = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type data_in,
   output logic     full,
   input  logic     pop,
   output item_type data_out,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: hdl/nvmeqp_front.sv
// Front stage: accepts items, owns the ring pointers and classifies each item.
module nvmeqp_front import nvmeqp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     push,
   input  req_type  req_item,
   output logic     full,
   output logic     work_push,
   output work_type work_item,
   input  logic     work_full
);

   logic [5:0] sq_tail_ff, sq_tail_in;
   logic [5:0] sq_head_ff, sq_head_in;
   logic [7:0] cq_head_ff, cq_head_in;
   logic       cq_phase_ff, cq_phase_in;

   logic       accept;
   logic [6:0] sq_size;
   logic [6:0] sq_step;
   logic [5:0] sq_next;
   logic [8:0] cq_size;
   logic [8:0] cq_step;
   logic       cq_wrap;
   logic [7:0] cq_next;
   logic [7:0] cpl_err;

   assign full   = work_full;
   assign accept = push & ~work_full;

   // Saturate ring sizes into their legal ranges
   always_comb begin
      if (cfg.sq_entries < 7'd2) begin
         sq_size = 7'd2;
      end else if (cfg.sq_entries > 7'(SQ_DEPTH_MAX)) begin
         sq_size = 7'(SQ_DEPTH_MAX);
      end else begin
         sq_size = cfg.sq_entries;
      end
      if (cfg.cq_entries < 9'd2) begin
         cq_size = 9'd2;
      end else if (cfg.cq_entries > 9'(CQ_DEPTH_MAX)) begin
         cq_size = 9'(CQ_DEPTH_MAX);
      end else begin
         cq_size = cfg.cq_entries;
      end
   end

   assign sq_step = {1'b0, sq_tail_ff} + 7'd1;
   assign sq_next = (sq_step >= sq_size) ? '0 : sq_step[5:0];
   assign cq_step = {1'b0, cq_head_ff} + 9'd1;
   assign cq_wrap = (cq_step >= cq_size);
   assign cq_next = cq_wrap ? '0 : cq_step[7:0];
   assign cpl_err = req_item.cqe_status[8:1];

   always_comb begin
      sq_tail_in  = sq_tail_ff;
      sq_head_in  = sq_head_ff;
      cq_head_in  = cq_head_ff;
      cq_phase_in = cq_phase_ff;
      work_push   = 1'b0;
      work_item   = '0;
      work_item.is_write    = req_item.is_write;
      work_item.buf_addr    = req_item.buf_addr;
      work_item.start_block = req_item.start_block;
      work_item.block_count = req_item.block_count;
      if (accept) begin
         if (req_item.func == FUNC_SUBMIT) begin
            // Drop zero-length requests before the full check
            if (req_item.block_count != '0) begin
               work_push = 1'b1;
               if (sq_next == sq_head_ff) begin
                  work_item.kind = KIND_FULL;
               end else begin
                  work_item.kind     = KIND_ISSUED;
                  work_item.slot     = sq_tail_ff;
                  work_item.doorbell = {2'b00, sq_next};
                  sq_tail_in         = sq_next;
               end
            end
         end else if (req_item.cqe_status[0] == cq_phase_ff) begin
            // Consume only entries whose phase matches; stale ones drop
            work_push            = 1'b1;
            work_item.kind       = (cpl_err != '0) ? KIND_CPL_ERR : KIND_CPL_OK;
            work_item.doorbell   = cq_next;
            work_item.error_code = cpl_err;
            cq_head_in           = cq_next;
            sq_head_in           = req_item.cqe_sq_head;
            if (cq_wrap) begin
               cq_phase_in = ~cq_phase_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_tail_ff  <= '0;
         sq_head_ff  <= '0;
         cq_head_ff  <= '0;
         cq_phase_ff <= 1'b1;
      end else begin
         sq_tail_ff  <= sq_tail_in;
         sq_head_ff  <= sq_head_in;
         cq_head_ff  <= cq_head_in;
         cq_phase_ff <= cq_phase_in;
      end
   end

endmodule

FILE: hdl/nvmeqp_back.sv
// Back stage: clamps the transfer length and assembles the result words.
module nvmeqp_back import nvmeqp_pkg::*; (
   input  cfg_type  cfg,
   input  logic     work_empty,
   input  work_type work_item,
   output logic     work_pop,
   input  logic     rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp_item
);

   logic [1:0]  bs_off;
   logic [3:0]  page_blocks;
   logic [2:0]  offset_blocks;
   logic [3:0]  max_page;
   logic [4:0]  mx_exp;
   logic [18:0] mx_blocks;
   logic [16:0] count;
   logic [16:0] count_m1;

   assign work_pop = ~work_empty & ~rsp_full;
   assign rsp_push = work_pop;

   // Block size saturates into 512..4096 bytes; keep the offset from 512
   always_comb begin
      if (cfg.block_size_log2 < 4'd9) begin
         bs_off = 2'd0;
      end else if (cfg.block_size_log2 > 4'd12) begin
         bs_off = 2'd3;
      end else begin
         bs_off = 2'(cfg.block_size_log2 - 4'd9);
      end
   end

   // Blocks left in the buffer's page
   assign page_blocks   = 4'd8 >> bs_off;
   assign offset_blocks = work_item.buf_addr[11:9] >> bs_off;
   assign max_page      = page_blocks - {1'b0, offset_blocks};

   // Transfer limit in blocks: 2^(limit exponent + 12 - block size log2)
   assign mx_exp    = {1'b0, cfg.max_transfer_log2} + 5'd3 - {3'b000, bs_off};
   assign mx_blocks = 19'd1 << mx_exp;

   always_comb begin
      count = work_item.block_count;
      if (count > {13'b0, max_page}) begin
         count = {13'b0, max_page};
      end
      if ((cfg.max_transfer_log2 != '0) && ({2'b00, count} > mx_blocks)) begin
         count = mx_blocks[16:0];
      end
   end

   assign count_m1 = count - 17'd1;

   always_comb begin
      rsp_item                = '0;
      rsp_item.kind           = work_item.kind;
      rsp_item.doorbell_value = work_item.doorbell;
      rsp_item.error_code     = work_item.error_code;
      if (work_item.kind == KIND_ISSUED) begin
         rsp_item.slot_index    = work_item.slot;
         rsp_item.cmd_dword0    = {10'b0, work_item.slot, 8'b0,
                                   work_item.is_write ? OPC_WRITE : OPC_READ};
         rsp_item.data_pointer  = work_item.buf_addr;
         rsp_item.cmd_namespace = cfg.namespace_id;
         rsp_item.cmd_block     = work_item.start_block;
         rsp_item.cmd_dword12   = {1'b1, 15'b0, count_m1[15:0]};
         rsp_item.granted_count = count;
      end
   end

endmodule

FILE: hdl/nvme_io_queue_pair_host.sv
// Top level of the host-side NVMe I/O queue pair engine.
//
// Input channel: present a request on req_item and raise push; the beat is taken at a
// clock edge with push high and full low. A submit beat (func 0) clamps its block count
// to the buffer's page and the transfer limit, takes the submission tail slot and gives
// the command words with the new tail as doorbell value; with the ring full it gives a
// reject result. A completion beat (func 1) is the entry at the completion head; with a
// matching phase it advances the head, flips the phase on wrap, copies the submission
// head and gives the new head with the status code. Zero-count submits and stale
// completions give no result.
// Result channel: a result waits on rsp_item while empty is low and leaves at an edge
// with pop high. Results keep input order.
// Pipeline: the front stage writes an accepted beat into the middle queue, the back stage
// moves it into the result queue, and the receiver pops it from there; back-pressure can
// hold a beat in either queue. Throughput: one beat per cycle while full stays low,
// set by the pointer update in the front stage.
// Stall: when pop stays low the result queue fills, then the middle queue, then full
// rises; nothing is lost. Reset clears both queues and the ring pointers (phase to one)
// and loads the register defaults. The APB port writes with pready always high.
module nvme_io_queue_pair_host import nvmeqp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_item,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_item,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers
   logic [3:0]  block_size_log2_ff, block_size_log2_in;
   logic [3:0]  max_transfer_log2_ff, max_transfer_log2_in;
   logic [31:0] namespace_id_ff, namespace_id_in;
   logic [6:0]  sq_entries_ff, sq_entries_in;
   logic [8:0]  cq_entries_ff, cq_entries_in;

   logic        csr_write;
   logic [2:0]  csr_index;
   cfg_type     cfg;

   logic        work_push, work_full, work_pop, work_empty;
   work_type    work_in, work_out;
   logic        rsp_push, rsp_full;
   rsp_type     rsp_in;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[4:2];

   always_comb begin
      block_size_log2_in   = block_size_log2_ff;
      max_transfer_log2_in = max_transfer_log2_ff;
      namespace_id_in      = namespace_id_ff;
      sq_entries_in        = sq_entries_ff;
      cq_entries_in        = cq_entries_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BLOCK_SIZE:   block_size_log2_in   = pwdata[3:0];
            REG_MAX_TRANSFER: max_transfer_log2_in = pwdata[3:0];
            REG_NAMESPACE:    namespace_id_in      = pwdata;
            REG_SQ_ENTRIES:   sq_entries_in        = pwdata[6:0];
            REG_CQ_ENTRIES:   cq_entries_in        = pwdata[8:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BLOCK_SIZE:   prdata = {28'b0, block_size_log2_ff};
         REG_MAX_TRANSFER: prdata = {28'b0, max_transfer_log2_ff};
         REG_NAMESPACE:    prdata = namespace_id_ff;
         REG_SQ_ENTRIES:   prdata = {25'b0, sq_entries_ff};
         REG_CQ_ENTRIES:   prdata = {23'b0, cq_entries_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_log2_ff   <= 4'd9;
         max_transfer_log2_ff <= 4'd0;
         namespace_id_ff      <= 32'd1;
         sq_entries_ff        <= 7'd64;
         cq_entries_ff        <= 9'd256;
      end else begin
         block_size_log2_ff   <= block_size_log2_in;
         max_transfer_log2_ff <= max_transfer_log2_in;
         namespace_id_ff      <= namespace_id_in;
         sq_entries_ff        <= sq_entries_in;
         cq_entries_ff        <= cq_entries_in;
      end
   end

   assign cfg.block_size_log2   = block_size_log2_ff;
   assign cfg.max_transfer_log2 = max_transfer_log2_ff;
   assign cfg.namespace_id      = namespace_id_ff;
   assign cfg.sq_entries        = sq_entries_ff;
   assign cfg.cq_entries        = cq_entries_ff;

   // Front: accept and classify, advance ring pointers
   nvmeqp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .work_push (work_push),
      .work_item (work_in),
      .work_full (work_full)
   );

   // Decouple front and back
   nvmeqp_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (work_type)
   ) u_work_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (work_push),
      .data_in  (work_in),
      .full     (work_full),
      .pop      (work_pop),
      .data_out (work_out),
      .empty    (work_empty)
   );

   // Back: clamp count and build result words
   nvmeqp_back u_back (
      .cfg        (cfg),
      .work_empty (work_empty),
      .work_item  (work_out),
      .work_pop   (work_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_in)
   );

   // Hold finished results until the receiver pops them
   nvmeqp_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .data_in  (rsp_in),
      .full     (rsp_full),
      .pop      (pop),
      .data_out (rsp_item),
      .empty    (empty)
   );

endmodule

FILE: hdl/nvmeqp_checker.sv
// Port-level checks of the queue pair engine and their binding to the top level.
module nvmeqp_checker import nvmeqp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_item
);

   // Reset leaves both sides idle
   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   // A waiting result holds while the receiver stalls
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("result changed while stalled");

   // An issued command carries a nonzero count and a matching command word
   a_issued_words: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.kind == KIND_ISSUED) |->
         (rsp_item.granted_count != '0 && rsp_item.cmd_dword12[31] &&
          rsp_item.cmd_dword0[21:16] == rsp_item.slot_index &&
          rsp_item.error_code == '0))
      else $error("issued command words inconsistent");

   // Rejects and completions carry no command words; a good completion has no error code
   a_no_cmd_words: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.kind != KIND_ISSUED) |->
         (rsp_item.granted_count == '0 && rsp_item.cmd_dword12 == '0 &&
          (rsp_item.kind != KIND_CPL_OK || rsp_item.error_code == '0)))
      else $error("command words on a non-issue result");

endmodule

bind nvme_io_queue_pair_host nvmeqp_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);

FILE: test/nvme_io_queue_pair_host_tb.sv
// Self-checking testbench for the NVMe I/O queue pair host engine.
module nvme_io_queue_pair_host_tb;
   import nvmeqp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT     = 2000;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_RESULTS  = 80;
   localparam int SETTLE_CYCLES  = 6;
   localparam int REPORT_LINES   = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_item = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   nvme_io_queue_pair_host dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_item(req_item),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // Shadow of the register file and the ring pointers, as the engine should hold them.
   cfg_type shadow_cfg = '{block_size_log2: 4'd9, max_transfer_log2: 4'd0,
                           namespace_id: 32'd1, sq_entries: 7'd64, cq_entries: 9'd256};
   int ring_sq_tail  = 0;
   int ring_sq_head  = 0;
   int ring_cq_head  = 0;
   bit ring_cq_phase = 1'b1;

   // Results the engine owes us, oldest first.
   rsp_type expected_results[$];
   rsp_type oldest_result;

   int mismatch_count = 0;
   int idle_cycles    = 0;
   bit calm           = 1'b0;
   int stall_left     = 0;

   typedef struct {
      bit         is_cfg;
      logic [2:0] reg_idx;
      logic [31:0] reg_val;
      req_type    item;
      bit         fixed;
      bit         fixed_has;
      rsp_type    fixed_rsp;
   } plan_row_type;

   plan_row_type directed_plan[$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < REPORT_LINES)
         $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic int clamp_to(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [31:0] val);
      case (idx)
         REG_BLOCK_SIZE:   shadow_cfg.block_size_log2 = val[3:0];
         REG_MAX_TRANSFER: shadow_cfg.max_transfer_log2 = val[3:0];
         REG_NAMESPACE:    shadow_cfg.namespace_id = val;
         REG_SQ_ENTRIES:   shadow_cfg.sq_entries = val[6:0];
         REG_CQ_ENTRIES:   shadow_cfg.cq_entries = val[8:0];
         default: ;
      endcase
   endfunction

   // Advance the ring model by one beat; returns 1 when the beat owes a result.
   function automatic bit predict_queue_pair(input req_type it, output rsp_type res);
      int         nsq;
      int         ncq;
      int         nxt;
      int         bs;
      int         cnt;
      int         maxc;
      longint     mx;
      logic [7:0] err;
      logic [7:0] opc;
      res = '0;
      if (it.func == FUNC_SUBMIT) begin
         if (it.block_count == 0) return 1'b0;
         nsq = clamp_to(int'(shadow_cfg.sq_entries), 2, SQ_DEPTH_MAX);
         nxt = (ring_sq_tail + 1 >= nsq) ? 0 : ring_sq_tail + 1;
         if (nxt == ring_sq_head) begin
            res.kind = KIND_FULL;
            return 1'b1;
         end
         bs = clamp_to(int'(shadow_cfg.block_size_log2), 9, 12);
         // stay inside the buffer's page, then honor the transfer limit
         maxc = (4096 >> bs) - (int'(it.buf_addr[11:0]) >> bs);
         cnt = int'(it.block_count);
         if (cnt > maxc) cnt = maxc;
         if (shadow_cfg.max_transfer_log2 != 0) begin
            mx = ((longint'(1) << shadow_cfg.max_transfer_log2) * 4096) >> bs;
            if (cnt > mx) cnt = int'(mx);
         end
         opc = it.is_write ? OPC_WRITE : OPC_READ;
         res.kind = KIND_ISSUED;
         res.slot_index = 6'(ring_sq_tail);
         res.cmd_dword0 = {10'b0, 6'(ring_sq_tail), 8'h00, opc};
         res.data_pointer = it.buf_addr;
         res.cmd_namespace = shadow_cfg.namespace_id;
         res.cmd_block = it.start_block;
         res.cmd_dword12 = {1'b1, 15'b0, 16'(cnt - 1)};
         res.granted_count = 17'(cnt);
         ring_sq_tail = nxt;
         res.doorbell_value = 8'(ring_sq_tail);
         return 1'b1;
      end
      if (it.cqe_status[0] != ring_cq_phase) return 1'b0;
      ncq = clamp_to(int'(shadow_cfg.cq_entries), 2, CQ_DEPTH_MAX);
      nxt = (ring_cq_head + 1 >= ncq) ? 0 : ring_cq_head + 1;
      if (nxt == 0) ring_cq_phase = ~ring_cq_phase;
      ring_cq_head = nxt;
      ring_sq_head = int'(it.cqe_sq_head);
      err = it.cqe_status[8:1];
      res.kind = (err != 0) ? KIND_CPL_ERR : KIND_CPL_OK;
      res.doorbell_value = 8'(ring_cq_head);
      res.error_code = err;
      return 1'b1;
   endfunction

   // Fields that a beat's function ignores still carry random bits.
   function automatic req_type mk_submit(input logic [47:0] buf_addr,
                                         input logic [63:0] lba,
                                         input logic [16:0] cnt, input logic wr);
      req_type it;
      it.func = FUNC_SUBMIT;
      it.buf_addr = buf_addr;
      it.start_block = lba;
      it.block_count = cnt;
      it.is_write = wr;
      it.cqe_status = 16'($urandom);
      it.cqe_sq_head = 6'($urandom);
      return it;
   endfunction

   function automatic req_type mk_completion(input logic [15:0] status,
                                             input logic [5:0] sq_head_seen);
      req_type it;
      it.func = FUNC_COMPLETE;
      it.buf_addr = 48'({$urandom, $urandom});
      it.start_block = {$urandom, $urandom};
      it.block_count = 17'($urandom_range(0, 65536));
      it.is_write = 1'($urandom);
      it.cqe_status = status;
      it.cqe_sq_head = sq_head_seen;
      return it;
   endfunction

   function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] val);
      plan_row_type row;
      row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, item: '0,
              fixed: 1'b0, fixed_has: 1'b0, fixed_rsp: '0};
      directed_plan.push_back(row);
   endfunction

   function automatic void add_item(input req_type it);
      plan_row_type row;
      row = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, item: it,
              fixed: 1'b0, fixed_has: 1'b0, fixed_rsp: '0};
      directed_plan.push_back(row);
   endfunction

   function automatic void add_fixed(input req_type it, input bit has, input rsp_type rsp);
      plan_row_type row;
      row = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, item: it,
              fixed: 1'b1, fixed_has: has, fixed_rsp: rsp};
      directed_plan.push_back(row);
   endfunction

   // Mostly a well-behaved host: submit while there is room, complete what is in flight
   // with the right phase. The rest is stale entries, empty submits and raw noise.
   function automatic req_type random_item();
      int          nsq;
      int          in_flight;
      int          pick;
      int          new_head;
      logic [7:0]  err;
      logic [16:0] cnt;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         return '{func: 1'($urandom), buf_addr: 48'({$urandom, $urandom}),
                  start_block: {$urandom, $urandom},
                  block_count: 17'($urandom_range(0, 65536)), is_write: 1'($urandom),
                  cqe_status: 16'($urandom), cqe_sq_head: 6'($urandom)};
      if (pick < 13)
         return mk_submit(48'({$urandom, $urandom}), {$urandom, $urandom}, '0,
                          1'($urandom));
      if (pick < 18)
         return mk_completion({15'($urandom), ~ring_cq_phase}, 6'($urandom));
      nsq = clamp_to(int'(shadow_cfg.sq_entries), 2, SQ_DEPTH_MAX);
      if (ring_sq_tail < nsq && ring_sq_head < nsq)
         in_flight = (ring_sq_tail - ring_sq_head + nsq) % nsq;
      else
         in_flight = -1;
      if (in_flight != 0 &&
          $urandom_range(0, 99) < ((in_flight >= nsq - 1) ? 70 : 40)) begin
         if (in_flight > 0)
            new_head = (ring_sq_head + $urandom_range(1, in_flight)) % nsq;
         else
            new_head = $urandom_range(0, nsq - 1);
         err = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
         return mk_completion({7'($urandom), err, ring_cq_phase}, 6'(new_head));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7)
         cnt = 17'($urandom_range(1, 16));
      else if (pick == 7)
         cnt = 17'd65536;
      else
         cnt = 17'($urandom_range(1, 65536));
      return mk_submit(48'({$urandom, $urandom}), {$urandom, $urandom}, cnt,
                       1'($urandom));
   endfunction

   // Drive one beat until taken, predict it, then maybe hold off for a burst.
   task automatic issue_item(input req_type it, input bit use_fixed, input bit fixed_has,
                             input rsp_type fixed_rsp, output bit got_result);
      rsp_type predicted;
      bit      has;
      push <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      has = predict_queue_pair(it, predicted);
      if (use_fixed) begin
         has = fixed_has;
         predicted = fixed_rsp;
      end
      if (has) expected_results.push_back(predicted);
      got_result = has;
      if (!calm && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Drop push, wait for every owed result, then let silent beats drain out of the pipe.
   task automatic settle();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup phase, access phase, then idle before the next transfer.
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      apply_csr(idx, val);
      @(posedge clock);
   endtask

   // Stimulus: reset, directed plan, then random phases under changing settings.
   initial begin
      req_type    it;
      bit         got;
      int         produced;
      logic [3:0] bs_val;
      logic [3:0] mt_val;
      logic [31:0] ns_val;
      logic [6:0] sq_val;
      logic [8:0] cq_val;

      // Defaults after reset: 512-byte blocks, no limit, namespace 1, full-size rings.
      add_fixed(mk_submit(48'h0, 64'h0, 17'd1, 1'b0), 1'b1,
                '{kind: KIND_ISSUED, slot_index: 6'd0, cmd_dword0: 32'h0000_0002,
                  data_pointer: 48'h0, cmd_namespace: 32'd1, cmd_block: 64'h0,
                  cmd_dword12: 32'h8000_0000, granted_count: 17'd1,
                  doorbell_value: 8'd1, error_code: 8'd0});
      // buffer at the last byte of a page: only one block fits
      add_fixed(mk_submit(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65536, 1'b1),
                1'b1,
                '{kind: KIND_ISSUED, slot_index: 6'd1, cmd_dword0: 32'h0001_0001,
                  data_pointer: 48'hFFFF_FFFF_FFFF, cmd_namespace: 32'd1,
                  cmd_block: 64'hFFFF_FFFF_FFFF_FFFF, cmd_dword12: 32'h8000_0000,
                  granted_count: 17'd1, doorbell_value: 8'd2, error_code: 8'd0});
      // zero count is swallowed
      add_fixed(mk_submit(48'h1234, 64'h55, 17'd0, 1'b1), 1'b0, '0);
      // page-aligned buffer: a whole page of blocks
      add_fixed(mk_submit(48'h1000, 64'h1_0000_0000, 17'd65536, 1'b0), 1'b1,
                '{kind: KIND_ISSUED, slot_index: 6'd2, cmd_dword0: 32'h0002_0002,
                  data_pointer: 48'h1000, cmd_namespace: 32'd1,
                  cmd_block: 64'h1_0000_0000, cmd_dword12: 32'h8000_0007,
                  granted_count: 17'd8, doorbell_value: 8'd3, error_code: 8'd0});
      // stale entry, then good, error and foreign-head entries
      add_fixed(mk_completion(16'h0000, 6'd3), 1'b0, '0);
      add_fixed(mk_completion(16'h0001, 6'd3), 1'b1,
                '{kind: KIND_CPL_OK, doorbell_value: 8'd1, default: '0});
      add_fixed(mk_completion(16'h01FF, 6'd63), 1'b1,
                '{kind: KIND_CPL_ERR, doorbell_value: 8'd2, error_code: 8'hFF,
                  default: '0});
      add_fixed(mk_completion(16'hFE01, 6'd3), 1'b1,
                '{kind: KIND_CPL_OK, doorbell_value: 8'd3, default: '0});
      add_item(mk_submit(48'h0_0800, 64'h77, 17'd5, 1'b1));
      // completion ring below its floor: wraps at two and flips the phase
      add_cfg(REG_CQ_ENTRIES, 32'd0);
      add_item(mk_completion(16'h0001, 6'd0));
      add_item(mk_completion(16'h0001, 6'd0));
      add_item(mk_completion(16'h0000, 6'd0));
      // submission ring below its floor with the tail already past it
      add_cfg(REG_SQ_ENTRIES, 32'd0);
      add_fixed(mk_submit(48'h2000, 64'h9, 17'd3, 1'b0), 1'b1,
                '{kind: KIND_FULL, default: '0});
      add_item(mk_completion(16'h0000, 6'd1));
      add_item(mk_submit(48'h2000, 64'h9, 17'd3, 1'b0));
      add_item(mk_submit(48'h3000, 64'hA, 17'd2, 1'b1));
      add_cfg(REG_SQ_ENTRIES, 32'd127);
      add_item(mk_submit(48'h3000, 64'hA, 17'd2, 1'b1));
      // block size above its ceiling, then below its floor
      add_cfg(REG_BLOCK_SIZE, 32'd15);
      add_item(mk_submit(48'h0, 64'hB, 17'd65536, 1'b1));
      add_item(mk_submit(48'h0_0FFF, 64'hC, 17'd4, 1'b0));
      add_cfg(REG_BLOCK_SIZE, 32'd0);
      add_cfg(REG_MAX_TRANSFER, 32'd15);
      add_cfg(REG_NAMESPACE, 32'hFFFF_FFFF);
      add_item(mk_submit(48'hABC_DEF0_0200, 64'hD, 17'd100, 1'b0));
      add_cfg(REG_CQ_ENTRIES, 32'd511);
      add_item(mk_completion({15'd0, ring_cq_phase}, 6'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg) begin
            settle();
            write_csr(directed_plan[i].reg_idx, directed_plan[i].reg_val);
         end else begin
            issue_item(directed_plan[i].item, directed_plan[i].fixed,
                       directed_plan[i].fixed_has, directed_plan[i].fixed_rsp, got);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         calm = (p == PHASE_COUNT - 1);
         case (p)
            0: begin
               bs_val = 4'd9;  mt_val = 4'd0;  ns_val = 32'd1;
               sq_val = 7'd2;  cq_val = 9'd2;
            end
            1: begin
               bs_val = 4'd12; mt_val = 4'd15; ns_val = 32'hFFFF_FFFF;
               sq_val = 7'd64; cq_val = 9'd256;
            end
            default: begin
               bs_val = 4'($urandom_range(0, 15));
               mt_val = 4'($urandom_range(0, 15));
               ns_val = $urandom;
               if (ns_val == 0) ns_val = 32'd1;
               sq_val = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(2, 12));
               cq_val = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                    : 9'($urandom_range(2, 40));
            end
         endcase
         write_csr(REG_BLOCK_SIZE, 32'(bs_val));
         write_csr(REG_MAX_TRANSFER, 32'(mt_val));
         write_csr(REG_NAMESPACE, ns_val);
         write_csr(REG_SQ_ENTRIES, 32'(sq_val));
         write_csr(REG_CQ_ENTRIES, 32'(cq_val));
         produced = 0;
         while (produced < PHASE_RESULTS) begin
            it = random_item();
            issue_item(it, 1'b0, 1'b0, '0, got);
            if (got) produced++;
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: check each beat against the oldest owed result, stall in bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", 64'(rsp_item.kind), '0);
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_item.kind !== oldest_result.kind)
                  report_mismatch("kind", 64'(rsp_item.kind), 64'(oldest_result.kind));
               if (rsp_item.slot_index !== oldest_result.slot_index)
                  report_mismatch("slot_index", 64'(rsp_item.slot_index),
                                  64'(oldest_result.slot_index));
               if (rsp_item.cmd_dword0 !== oldest_result.cmd_dword0)
                  report_mismatch("cmd_dword0", 64'(rsp_item.cmd_dword0),
                                  64'(oldest_result.cmd_dword0));
               if (rsp_item.data_pointer !== oldest_result.data_pointer)
                  report_mismatch("data_pointer", 64'(rsp_item.data_pointer),
                                  64'(oldest_result.data_pointer));
               if (rsp_item.cmd_namespace !== oldest_result.cmd_namespace)
                  report_mismatch("cmd_namespace", 64'(rsp_item.cmd_namespace),
                                  64'(oldest_result.cmd_namespace));
               if (rsp_item.cmd_block !== oldest_result.cmd_block)
                  report_mismatch("cmd_block", rsp_item.cmd_block, oldest_result.cmd_block);
               if (rsp_item.cmd_dword12 !== oldest_result.cmd_dword12)
                  report_mismatch("cmd_dword12", 64'(rsp_item.cmd_dword12),
                                  64'(oldest_result.cmd_dword12));
               if (rsp_item.granted_count !== oldest_result.granted_count)
                  report_mismatch("granted_count", 64'(rsp_item.granted_count),
                                  64'(oldest_result.granted_count));
               if (rsp_item.doorbell_value !== oldest_result.doorbell_value)
                  report_mismatch("doorbell_value", 64'(rsp_item.doorbell_value),
                                  64'(oldest_result.doorbell_value));
               if (rsp_item.error_code !== oldest_result.error_code)
                  report_mismatch("error_code", 64'(rsp_item.error_code),
                                  64'(oldest_result.error_code));
            end
         end
         // hold pop low through a burst, otherwise keep draining
         if (stall_left > 0 && !calm) begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any beat moving on either side means a hang.
   always @(posedge clock) begin
      if (reset || psel || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
